[sv/serial_mouse_odometer_defines.svh]
// Assertion macros for the serial mouse odometer.
// Included by files that carry concurrent checks; relies on clk and rst in scope.
`ifndef SERIAL_MOUSE_ODOMETER_DEFINES_SVH
`define SERIAL_MOUSE_ODOMETER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that is suspended while reset is high
`define SMO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also runs through reset
`define SMO_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMO_ASSERT(label, prop, msg)
`define SMO_ASSERT_RST(label, prop, msg)
`endif

`endif

[sv/smo_pkg.sv]
// Shared types, constants and helpers for the serial mouse odometer.
// No dependencies; imported by every module and interface of the block.
package smo_pkg;

  localparam int unsigned ByteW  = 7;
  localparam int unsigned SumW   = 16;
  localparam int unsigned TickW  = 16;
  localparam int unsigned DeltaW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned SyncBit = 6;

  localparam logic signed [SumW-1:0] AccMax = 16'sd32767;
  localparam logic signed [SumW-1:0] AccMin = -16'sd32767;
  localparam logic [TickW-1:0]       TickMax = 16'hFFFF;
  localparam logic [TickW-1:0]       WindowReset = 16'd100;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_TICKS      = 2'd0,
    REG_SWAP_AXES         = 2'd1,
    REG_NEGATE_HORIZONTAL = 2'd2,
    REG_NEGATE_VERTICAL   = 2'd3
  } cfg_reg_e;

  // Packet framing position
  typedef enum logic [1:0] {
    POS_SYNC   = 2'd0,
    POS_HEADER = 2'd1,
    POS_X      = 2'd2
  } pos_e;

  typedef struct packed {
    logic [TickW-1:0] window_ticks;
    logic             swap_axes;
    logic             negate_horizontal;
    logic             negate_vertical;
  } cfg_t;

  // One decoded packet from the framer
  typedef struct packed {
    logic                     done;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
  } packet_t;

  // Report handed to the output register
  typedef struct packed {
    logic                   valid;
    logic signed [SumW-1:0] h;
    logic signed [SumW-1:0] v;
  } report_t;

  // Saturating add of a signed delta into an accumulator in [-32767, 32767]
  function automatic logic signed [SumW-1:0] sat_add(
    input logic signed [SumW-1:0]   acc,
    input logic signed [DeltaW-1:0] d
  );
    logic signed [SumW:0] s;
    s = {acc[SumW-1], acc} + {{(SumW+1-DeltaW){d[DeltaW-1]}}, d};
    if (s > $signed({AccMax[SumW-1], AccMax})) begin
      return AccMax;
    end else if (s < $signed({AccMin[SumW-1], AccMin})) begin
      return AccMin;
    end else begin
      return s[SumW-1:0];
    end
  endfunction

endpackage

[sv/smo_item_if.sv]
// Input channel: received serial byte or millisecond tick.
// Depends on smo_pkg for field widths.
interface smo_item_if import smo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

[sv/smo_result_if.sv]
// Output channel: reported horizontal and vertical sums.
// Depends on smo_pkg for field widths.
interface smo_result_if import smo_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [SumW-1:0] horizontal_sum;
  logic signed [SumW-1:0] vertical_sum;

  modport source (output valid, horizontal_sum, vertical_sum, input ready);
  modport sink   (input valid, horizontal_sum, vertical_sum, output ready);
endinterface

[sv/smo_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on smo_pkg for widths.
interface smo_cfg_if import smo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TickW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/serial_mouse_odometer.sv]
// Channel  | Dir | Words carried
// ---------+-----+------------------------------------------------
// item     | in  | action (byte or tick), rx_byte
// result   | out | horizontal_sum, vertical_sum
// cfg      | in  | index, data (always ready)
//
// One word accepted per cycle while the output register is empty or taken. A word
// sits in the input register, is decoded and accumulated there, and a report lands
// in the output register, which drives result for the word that completes the packet.
// The input register drains only when the output register is empty or taken.
// Synchronous active-high reset clears framing, sums, tick count and config.
`include "serial_mouse_odometer_defines.svh"

module serial_mouse_odometer import smo_pkg::*; (
  input logic          clk,
  input logic          rst,
  smo_item_if.sink     item,
  smo_result_if.source result,
  smo_cfg_if.sink      cfg
);

  logic             in_q_valid;
  logic             in_q_action;
  logic [ByteW-1:0] in_q_byte;
  logic             proc_en;
  logic             out_valid;
  logic signed [SumW-1:0] out_h, out_v;

  cfg_t    cfg_regs;
  packet_t pkt;
  report_t rpt;

  assign cfg.ready = 1'b1;

  smo_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // Input register
  assign proc_en    = in_q_valid && (!out_valid || result.ready);
  assign item.ready = !in_q_valid || proc_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (item.ready) begin
      in_q_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_q_action <= item.action;
      in_q_byte   <= item.rx_byte;
    end
  end

  smo_decoder u_dec (
    .clk     (clk),
    .rst     (rst),
    .byte_en (proc_en && !in_q_action),
    .rx_byte (in_q_byte),
    .pkt     (pkt)
  );

  smo_accum u_acc (
    .clk     (clk),
    .rst     (rst),
    .tick_en (proc_en && in_q_action),
    .pkt     (pkt),
    .cfg     (cfg_regs),
    .rpt     (rpt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rpt.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rpt.valid) begin
      out_h <= rpt.h;
      out_v <= rpt.v;
    end
  end

  assign result.valid          = out_valid;
  assign result.horizontal_sum = out_h;
  assign result.vertical_sum   = out_v;

  // Checks
  `SMO_ASSERT_RST(a_rst_clears_out, rst |=> !result.valid, "result valid after reset")
  `SMO_ASSERT(a_report_from_byte, rpt.valid |-> (proc_en && !in_q_action),
              "report without a processed byte")
  `SMO_ASSERT(a_stall_holds_input, (in_q_valid && out_valid && !result.ready) |-> !item.ready,
              "input taken while output blocked")
  `SMO_ASSERT(a_sum_range,
              result.valid |-> (result.horizontal_sum != 16'sh8000 &&
                                result.vertical_sum != 16'sh8000),
              "reported sum out of range")

endmodule

[sv/smo_cfg_regs.sv]
// Configuration register file: window length, axis swap and negation flags.
// Depends on smo_pkg.
module smo_cfg_regs import smo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [TickW-1:0]   wr_data,
  output cfg_t               cfg
);

  // Register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ticks      <= WindowReset;
      cfg.swap_axes         <= 1'b0;
      cfg.negate_horizontal <= 1'b0;
      cfg.negate_vertical   <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_reg_e'(wr_index))
        REG_WINDOW_TICKS:      cfg.window_ticks      <= wr_data;
        REG_SWAP_AXES:         cfg.swap_axes         <= wr_data[0];
        REG_NEGATE_HORIZONTAL: cfg.negate_horizontal <= wr_data[0];
        REG_NEGATE_VERTICAL:   cfg.negate_vertical   <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

[sv/smo_decoder.sv]
// Packet framer: resyncs on bit 6, rebuilds signed X and Y deltas.
// Depends on smo_pkg.
module smo_decoder import smo_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_en,
  input  logic [ByteW-1:0] rx_byte,
  output packet_t          pkt
);

  pos_e       pos, pos_next;
  logic [6:0] header_byte;
  logic [5:0] x_delta_low;

  logic sync;
  assign sync = rx_byte[SyncBit];

  // Framing position
  always_comb begin
    pos_next = pos;
    if (byte_en) begin
      if (sync) begin
        pos_next = POS_HEADER;
      end else begin
        unique case (pos)
          POS_HEADER: pos_next = POS_X;
          default:    pos_next = POS_SYNC;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_SYNC;
    end else begin
      pos <= pos_next;
    end
  end

  // Header and X low bits (guarded by position, no reset needed)
  always_ff @(posedge clk) begin
    if (byte_en && sync) begin
      header_byte <= rx_byte;
    end
    if (byte_en && !sync && pos == POS_HEADER) begin
      x_delta_low <= rx_byte[5:0];
    end
  end

  // Third byte completes the packet
  assign pkt.done = byte_en && !sync && pos == POS_X;
  assign pkt.dx   = {header_byte[1:0], x_delta_low};
  assign pkt.dy   = {header_byte[3:2], rx_byte[5:0]};

endmodule

[sv/smo_accum.sv]
// Saturating accumulators, tick counter and report decision.
// Depends on smo_pkg.
module smo_accum import smo_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    tick_en,
  input  packet_t pkt,
  input  cfg_t    cfg,
  output report_t rpt
);

  logic signed [SumW-1:0] horizontal_acc, vertical_acc;
  logic signed [SumW-1:0] h_new, v_new, h_sel, v_sel;
  logic [TickW-1:0]       elapsed_ticks;

  assign h_new = sat_add(horizontal_acc, pkt.dx);
  assign v_new = sat_add(vertical_acc, pkt.dy);

  // Report when a packet completes with the window reached
  assign rpt.valid = pkt.done && (elapsed_ticks >= cfg.window_ticks);

  assign h_sel = cfg.swap_axes ? v_new : h_new;
  assign v_sel = cfg.swap_axes ? h_new : v_new;
  assign rpt.h = cfg.negate_horizontal ? -h_sel : h_sel;
  assign rpt.v = cfg.negate_vertical   ? -v_sel : v_sel;

  // Accumulators and elapsed count
  always_ff @(posedge clk) begin
    if (rst) begin
      horizontal_acc <= '0;
      vertical_acc   <= '0;
      elapsed_ticks  <= '0;
    end else if (rpt.valid) begin
      horizontal_acc <= '0;
      vertical_acc   <= '0;
      elapsed_ticks  <= '0;
    end else if (pkt.done) begin
      horizontal_acc <= h_new;
      vertical_acc   <= v_new;
    end else if (tick_en && elapsed_ticks != TickMax) begin
      elapsed_ticks <= elapsed_ticks + 1'b1;
    end
  end

endmodule
